### sv/bbss_pkg.sv
`default_nettype none
package bbss_pkg;

  // input data width; only the low DATA_WIDTH bits of each field are used
  localparam int DATA_WIDTH = 32;

  localparam int FIELD_W = 32;
  localparam int ACC_W   = 64;
  localparam int FRAC_W  = 24;
  localparam int GAMMA_W = 32;
  localparam int GFRAC_W = 16;

  // difference magnitudes and the split multiplier operand
  localparam int MAG_W  = DATA_WIDTH + 1;
  localparam int LO_W   = (MAG_W + 1) / 2;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PP_W   = MAG_W + LO_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int TERM_W = PROD_W - FRAC_W;
  localparam int CNT_W  = $clog2(GAMMA_W);

  localparam logic [ACC_W-1:0]   ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]   ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [GAMMA_W-1:0] GAMMA_MAX = {GAMMA_W{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_ACC,
    S_CHK,
    S_OVF,
    S_DIV,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/bbss_in_if.sv
`default_nettype none
interface bbss_in_if;
  import bbss_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] x_prev;
  logic signed [FIELD_W-1:0] x_cur;
  logic signed [FIELD_W-1:0] grad_prev;
  logic signed [FIELD_W-1:0] grad_cur;
  logic                      last;

  modport source (output valid, x_prev, x_cur, grad_prev, grad_cur, last, input ready);
  modport sink (input valid, x_prev, x_cur, grad_prev, grad_cur, last, output ready);
endinterface
`default_nettype wire

### sv/bbss_out_if.sv
`default_nettype none
interface bbss_out_if;
  import bbss_pkg::*;

  logic               valid;
  logic               ready;
  logic [GAMMA_W-1:0] gamma;
  logic               zero_denominator;
  logic               saturated;

  modport source (output valid, gamma, zero_denominator, saturated, input ready);
  modport sink (input valid, gamma, zero_denominator, saturated, output ready);
endinterface
`default_nettype wire

### sv/barzilai_borwein_step_size_top.sv
// Barzilai-Borwein step size. Each transaction on points carries one grid point (previous and
// current model value and gradient, signed Q8.24). The block accumulates dx*dg and dg*dg in
// saturating 64-bit Q.24 sums and, on the point marked last, returns |sum dx*dg| / sum dg*dg as
// an unsigned Q16.16 gamma on result, then clears its sums. The four partial products of a
// point go through one shared 33x17 multiplier, so the block takes no new point until it has
// added the last partial product of the current one. A last point then goes through a
// magnitude step, an overflow compare and a 32-step restoring divider at one quotient bit per
// cycle, plus a load into the output register, which waits if an earlier result was not taken.
// A zero denominator skips the compare and the divider and a clipped gamma skips the divider.
// points.ready is high only while the block is idle.
`default_nettype none
module barzilai_borwein_step_size_top (
  input  wire          clk,
  input  wire          rst,
  bbss_in_if.sink      points,
  bbss_out_if.source   result
);
  import bbss_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt;

  logic signed [ACC_W-1:0] num;
  logic signed [ACC_W-1:0] den;
  logic                    ovf;

  logic [MAG_W-1:0]  dx_mag;
  logic [MAG_W-1:0]  dg_mag;
  logic              prod_neg;
  logic              is_last;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] prod;

  logic [ACC_W-1:0]   rem;
  logic [GAMMA_W-1:0] low_bits;
  logic [GAMMA_W-1:0] gam;
  logic               zd;
  logic               sat_r;

  logic               out_valid;
  logic [GAMMA_W-1:0] out_gamma;
  logic               out_zd;
  logic               out_sat;

  logic in_acc;
  logic done_ok;

  // differences of the sign-extended inputs
  logic signed [MAG_W-1:0] dx;
  logic signed [MAG_W-1:0] dg;

  always_comb begin
    dx = {points.x_cur[DATA_WIDTH-1], points.x_cur[DATA_WIDTH-1:0]}
       - {points.x_prev[DATA_WIDTH-1], points.x_prev[DATA_WIDTH-1:0]};
    dg = {points.grad_cur[DATA_WIDTH-1], points.grad_cur[DATA_WIDTH-1:0]}
       - {points.grad_prev[DATA_WIDTH-1], points.grad_prev[DATA_WIDTH-1:0]};
  end

  // shared multiplier: cnt[1] picks the product, cnt[0] the half of dg
  logic [MAG_W-1:0] mul_a;
  logic [LO_W-1:0]  mul_b;

  always_comb begin
    mul_a = cnt[1] ? dg_mag : dx_mag;
    mul_b = cnt[0] ? LO_W'({1'b0, dg_mag[MAG_W-1:LO_W]}) : dg_mag[LO_W-1:0];
  end

  // saturating accumulate of the Q.24 product
  logic [TERM_W-1:0] term_mag;
  logic [ACC_W-1:0]  term;
  logic [ACC_W-1:0]  acc_sel;
  logic [ACC_W-1:0]  acc_sum;
  logic              acc_wrap;
  logic [ACC_W-1:0]  acc_new;

  always_comb begin
    term_mag = prod[PROD_W-1:FRAC_W];
    term     = {{(ACC_W-TERM_W){1'b0}}, term_mag};
    if (prod_neg && !cnt[1]) begin
      term = ACC_W'(0) - term;
    end
    acc_sel  = cnt[1] ? den : num;
    acc_sum  = acc_sel + term;
    acc_wrap = (acc_sel[ACC_W-1] == term[ACC_W-1]) && (acc_sum[ACC_W-1] != acc_sel[ACC_W-1]);
    acc_new  = acc_wrap ? (acc_sel[ACC_W-1] ? ACC_MIN : ACC_MAX) : acc_sum;
  end

  // one restoring division step
  logic [ACC_W:0] trial;
  logic           take;
  logic [ACC_W:0] trial_diff;
  logic [ACC_W-1:0] num_mag;
  logic           den_zero;
  logic           q_big;

  always_comb begin
    trial      = {rem, low_bits[GAMMA_W-1]};
    take       = trial >= {1'b0, den};
    trial_diff = trial - {1'b0, den};
    num_mag    = num[ACC_W-1] ? (ACC_W'(0) - num) : num;
    den_zero   = (den == '0) || den[ACC_W-1];
    q_big      = rem >= den;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (points.valid) state_next = S_MUL;
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = cnt[0] ? S_ACC : S_MUL;
      S_ACC: begin
        if (!cnt[1]) state_next = S_MUL;
        else if (is_last) state_next = S_CHK;
        else state_next = S_IDLE;
      end
      S_CHK:  state_next = den_zero ? S_DONE : S_OVF;
      S_OVF:  state_next = q_big ? S_DONE : S_DIV;
      S_DIV:  if (cnt == CNT_W'(GAMMA_W - 1)) state_next = S_DONE;
      S_DONE: if (done_ok) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    points.ready = (state == S_IDLE);
    in_acc       = points.valid && (state == S_IDLE);
    done_ok      = !out_valid || result.ready;
  end

  assign result.valid            = out_valid;
  assign result.gamma            = out_gamma;
  assign result.zero_denominator = out_zd;
  assign result.saturated        = out_sat;

  // control and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      num       <= '0;
      den       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && done_ok) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_acc) cnt <= '0;
        S_ADD:  if (!cnt[0]) cnt <= cnt + 1'b1;
        S_ACC: begin
          cnt <= cnt + 1'b1;
          if (cnt[1]) den <= acc_new;
          else num <= acc_new;
          if (acc_wrap) ovf <= 1'b1;
        end
        S_OVF:  cnt <= '0;
        S_DIV:  cnt <= cnt + 1'b1;
        S_DONE: begin
          if (done_ok) begin
            num       <= '0;
            den       <= '0;
            ovf       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dx_mag   <= dx[MAG_W-1] ? (MAG_W'(0) - dx) : dx;
        dg_mag   <= dg[MAG_W-1] ? (MAG_W'(0) - dg) : dg;
        prod_neg <= dx[MAG_W-1] ^ dg[MAG_W-1];
        is_last  <= points.last;
      end
      S_MUL: pp <= PP_W'(mul_a * mul_b);
      S_ADD: prod <= cnt[0] ? (prod + PROD_W'({pp, {LO_W{1'b0}}})) : PROD_W'(pp);
      S_CHK: begin
        rem      <= {{GFRAC_W{1'b0}}, num_mag[ACC_W-1:GFRAC_W]};
        low_bits <= {num_mag[GFRAC_W-1:0], {(GAMMA_W-GFRAC_W){1'b0}}};
        sat_r    <= ovf;
        zd       <= den_zero;
        gam      <= GAMMA_MAX;
      end
      S_OVF: if (q_big) sat_r <= 1'b1;
      S_DIV: begin
        rem      <= take ? trial_diff[ACC_W-1:0] : trial[ACC_W-1:0];
        low_bits <= {low_bits[GAMMA_W-2:0], 1'b0};
        gam      <= {gam[GAMMA_W-2:0], take};
      end
      S_DONE: begin
        if (done_ok) begin
          out_gamma <= gam;
          out_zd    <= zd;
          out_sat   <= sat_r;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### sv/bbss_check.sv
`default_nettype none
module bbss_check (
  input wire                            clk,
  input wire                            rst,
  input wire                            in_valid,
  input wire                            in_ready,
  input wire                            out_valid,
  input wire                            out_ready,
  input wire [bbss_pkg::GAMMA_W-1:0]    gamma,
  input wire                            zero_denominator,
  input wire                            saturated
);
  import bbss_pkg::*;

  // one point at a time through the shared multiplier
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after a transaction on points");

  a_zero_den_gamma: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_denominator) |-> (gamma == GAMMA_MAX))
    else $error("zero denominator without maximum gamma");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(gamma) &&
      $stable(zero_denominator) && $stable(saturated)))
    else $error("pending result changed before its transaction");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind barzilai_borwein_step_size_top bbss_check u_bbss_check (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (points.valid),
  .in_ready         (points.ready),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .gamma            (result.gamma),
  .zero_denominator (result.zero_denominator),
  .saturated        (result.saturated)
);
`default_nettype wire
